@@ design/binary_min_heap_queue_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue unit
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define BHQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared constants, codes and types of the binary min-heap queue unit.
// ----------------------------------------------------------------------------
package bhq_pkg;

   localparam int CAPACITY  = 32;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int IDX_W     = CNT_W + 1;

   // Commands.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]           addr_type;
   typedef logic [CNT_W-1:0]            count_type;

   typedef struct packed {
      logic [1:0] status;
      key_type    removed_value;
      key_type    min_value;
      count_type  entry_count;
      logic       is_empty;
   } result_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
      addr_type rd0_addr;
      addr_type rd1_addr;
   } mem_req_type;

endpackage

@@ design/bhq_ram.sv @@
// ----------------------------------------------------------------------------
// bhq_ram
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bhq_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd0_addr,
   input  logic [ADDR_W-1:0] rd1_addr,
   output logic [WIDTH-1:0]  rd0_data,
   output logic [WIDTH-1:0]  rd1_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_data <= mem[rd0_addr];
      rd1_data <= mem[rd1_addr];
   end

endmodule

@@ design/bhq_engine.sv @@
// ----------------------------------------------------------------------------
// bhq_engine
// Heap sequencer: runs sift-up and sift-down against the heap RAM.
// ----------------------------------------------------------------------------
module bhq_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_valid,
   output logic                start_ready,
   input  logic                start_command,
   input  bhq_pkg::key_type    start_value,
   output logic                done_valid,
   input  logic                done_ready,
   output bhq_pkg::result_type done_result,
   output bhq_pkg::mem_req_type mem_req,
   input  bhq_pkg::key_type    rd0_data,
   input  bhq_pkg::key_type    rd1_data
);
   import bhq_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_UP    = 3'd2;
   localparam logic [2:0] S_DOWN  = 3'd3;
   localparam logic [2:0] S_PLACE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]  state_ff, state_in;
   count_type   count_ff, count_in;
   addr_type    pos_ff, pos_in;
   key_type     key_ff, key_in;
   key_type     root_ff, root_in;
   logic [1:0]  status_ff, status_in;
   key_type     removed_ff, removed_in;

   addr_type         up_parent;
   logic [IDX_W-1:0] dn_left, dn_right, dn_pick, dn_next_left;
   logic             dn_pick_right;
   key_type          dn_child;

   always_comb begin
      up_parent     = (pos_ff - addr_type'(1)) >> 1;
      dn_left       = (IDX_W'(pos_ff) << 1) + IDX_W'(1);
      dn_right      = dn_left + IDX_W'(1);
      dn_pick_right = (dn_right < IDX_W'(count_ff)) && (rd1_data < rd0_data);
      dn_child      = dn_pick_right ? rd1_data : rd0_data;
      dn_pick       = dn_pick_right ? dn_right : dn_left;
      dn_next_left  = (IDX_W'(dn_pick[ADDR_W-1:0]) << 1) + IDX_W'(1);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      root_in    = root_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      mem_req    = '0;
      start_ready = 1'b0;
      done_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            start_ready = 1'b1;
            if (start_valid) begin
               status_in  = ST_OK;
               removed_in = '0;
               if (start_command == CMD_POP) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     removed_in = root_ff;
                     count_in   = count_ff - count_type'(1);
                     if (count_ff == count_type'(1)) begin
                        state_in = S_DONE;
                     end else begin
                        mem_req.rd0_addr = count_in[ADDR_W-1:0];
                        state_in         = S_FETCH;
                     end
                  end
               end else begin
                  if (count_ff == count_type'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     key_in   = start_value;
                     count_in = count_ff + count_type'(1);
                     pos_in   = count_ff[ADDR_W-1:0];
                     if (count_ff == '0) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                        mem_req.wr_data = start_value;
                        root_in         = start_value;
                        state_in        = S_DONE;
                     end else begin
                        mem_req.rd0_addr = (pos_in - addr_type'(1)) >> 1;
                        state_in         = S_UP;
                     end
                  end
               end
            end
         end

         S_FETCH: begin
            // The former last entry arrives; it becomes the key that sinks.
            key_in = rd0_data;
            pos_in = '0;
            if (count_ff == count_type'(1)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = '0;
               mem_req.wr_data = rd0_data;
               root_in         = rd0_data;
               state_in        = S_DONE;
            end else begin
               mem_req.rd0_addr = addr_type'(1);
               mem_req.rd1_addr = addr_type'(2);
               state_in         = S_DOWN;
            end
         end

         S_UP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (key_ff < rd0_data) begin
               // Parent moves down into the hole; the hole climbs.
               mem_req.wr_data = rd0_data;
               pos_in          = up_parent;
               if (up_parent == '0) begin
                  state_in = S_PLACE;
               end else begin
                  mem_req.rd0_addr = (up_parent - addr_type'(1)) >> 1;
               end
            end else begin
               mem_req.wr_data = key_ff;
               state_in        = S_DONE;
            end
         end

         S_DOWN: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (dn_child < key_ff) begin
               // Smaller child moves up into the hole; the hole sinks.
               mem_req.wr_data = dn_child;
               if (pos_ff == '0) begin
                  root_in = dn_child;
               end
               pos_in = dn_pick[ADDR_W-1:0];
               if (dn_next_left >= IDX_W'(count_ff)) begin
                  state_in = S_PLACE;
               end else begin
                  mem_req.rd0_addr = dn_next_left[ADDR_W-1:0];
                  mem_req.rd1_addr = addr_type'(dn_next_left + IDX_W'(1));
               end
            end else begin
               mem_req.wr_data = key_ff;
               if (pos_ff == '0) begin
                  root_in = key_ff;
               end
               state_in = S_DONE;
            end
         end

         S_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = key_ff;
            if (pos_ff == '0) begin
               root_in = key_ff;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      done_result.status        = status_ff;
      done_result.removed_value = removed_ff;
      done_result.min_value     = (count_ff != '0) ? root_ff : key_type'(0);
      done_result.entry_count   = count_ff;
      done_result.is_empty      = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      root_ff    <= root_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

endmodule

@@ design/binary_min_heap_queue_unit.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Priority queue of signed keys held as a binary min-heap in one RAM.
// ----------------------------------------------------------------------------
// Usage: each beat on the req_ channel is one command. req_command low inserts
// req_value; req_command high pops the smallest stored key. Every request
// beat produces exactly one beat on the rsp_ channel carrying the status, the
// removed key (pops only), the minimum after the operation, the entry count
// and an empty flag. A full insert or an empty pop is refused with a status
// code and leaves the heap untouched.
// Sequencing: an insert sifts the new key up one heap level at a time and a
// pop first fetches the last entry, then sifts it down one level at a time;
// each level waits on a registered RAM read. Refusals and the trivial cases
// go straight to the response.
// Throughput: one request is in flight at a time; a new request is taken the
// cycle after the previous result has moved into the response register.
// Stalls: the response register holds its beat while rsp_ready is low; the
// engine may finish the next request meanwhile and waits behind it.
// Reset: synchronous and active high; it empties the heap. RAM contents are
// not cleared since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [31:0]        rsp_removed_value,
   output logic signed [31:0]        rsp_min_value,
   output logic [5:0]                rsp_entry_count,
   output logic                      rsp_is_empty
);
   import bhq_pkg::*;

   logic        done_valid;
   logic        done_ready;
   result_type  done_result;
   mem_req_type mem_req;
   key_type     rd0_data;
   key_type     rd1_data;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;

   // Heap storage: one write and two reads per cycle, read data registered.
   bhq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (mem_req.wr_en),
      .wr_addr  (mem_req.wr_addr),
      .wr_data  (mem_req.wr_data),
      .rd0_addr (mem_req.rd0_addr),
      .rd1_addr (mem_req.rd1_addr),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   // Sift sequencer.
   bhq_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start_valid   (req_valid),
      .start_ready   (req_ready),
      .start_command (req_command),
      .start_value   (req_value),
      .done_valid    (done_valid),
      .done_ready    (done_ready),
      .done_result   (done_result),
      .mem_req       (mem_req),
      .rd0_data      (rd0_data),
      .rd1_data      (rd1_data)
   );

   // The response register takes a new result when it is empty or being drained.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_valid && done_ready) begin
         rsp_data_ff <= done_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_removed_value = rsp_data_ff.removed_value;
   assign rsp_min_value     = rsp_data_ff.min_value;
   assign rsp_entry_count   = rsp_data_ff.entry_count;
   assign rsp_is_empty      = rsp_data_ff.is_empty;

endmodule

@@ design/bhq_checker.sv @@
// ----------------------------------------------------------------------------
// bhq_checker
// Port-level checks on the response channel of the heap queue unit.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_unit_macros.svh"

module bhq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_removed_value,
   input logic signed [31:0] rsp_min_value,
   input logic [5:0]         rsp_entry_count,
   input logic               rsp_is_empty
);
   import bhq_pkg::*;

   `BHQ_ASSERT_NOW(a_empty_flag, rsp_valid, rsp_is_empty == (rsp_entry_count == 6'd0), "empty flag disagrees with count")
   `BHQ_ASSERT_NOW(a_empty_min, rsp_valid && rsp_is_empty, rsp_min_value == 32'sd0, "empty heap reports a nonzero minimum")
   `BHQ_ASSERT_NOW(a_refused_count, rsp_valid && (rsp_status == ST_FULL), rsp_entry_count == 6'(CAPACITY), "full refusal with heap not full")
   `BHQ_ASSERT_NOW(a_refused_removed, rsp_valid && (rsp_status != ST_OK), rsp_removed_value == 32'sd0 && (rsp_status == ST_FULL || rsp_entry_count == 6'd0), "refused beat inconsistent")
   `BHQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_min_value), "response beat dropped while stalled")

endmodule

bind binary_min_heap_queue_unit bhq_checker u_bhq_checker (.*);
